[sv/pmse_pkg.sv]
package pmse_pkg;

	// Block sizing
	localparam int CHANNELS        = 8;
	localparam int MAX_SAMPLES     = 1024;
	localparam int SAMPLE_BITS     = 14;
	localparam int MIN_SAMPLES     = 2;
	localparam int DEFAULT_SAMPLES = 100;

	// Port widths fixed by the interface
	localparam int CH_W  = 3;
	localparam int SMP_W = 14;
	localparam int CFG_W = 11;
	localparam int OUT_W = 18;

	// Accumulator widths
	localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_SAMPLES);
	localparam int SQR_W  = 2 * SAMPLE_BITS;
	localparam int SQ_W   = 2 * SAMPLE_BITS + $clog2(MAX_SAMPLES);

	// Statistics datapath widths
	localparam int MEAN_FRAC  = 4;
	localparam int VAR_FRAC   = 2 * MEAN_FRAC;
	localparam int SQ_LO_W    = (SQ_W + 1) / 2;
	localparam int SQ_HI_W    = SQ_W - SQ_LO_W;
	localparam int PLO_W      = CNT_W + SQ_LO_W;
	localparam int PHI_W      = CNT_W + SQ_HI_W;
	localparam int A_W        = CNT_W + SQ_W;
	localparam int B_W        = 2 * SUM_W;
	localparam int DEN_W      = 2 * CNT_W;
	localparam int MEAN_DVD_W = SUM_W + MEAN_FRAC;
	localparam int DVD_W      = A_W + VAR_FRAC;
	localparam int DSR_W      = DEN_W;
	localparam int STEP_W     = $clog2(DVD_W + 1);
	localparam int RAD_W      = 2 * ((DVD_W + 1) / 2);
	localparam int ROOT_W     = RAD_W / 2;
	localparam int REM_W      = ROOT_W + 2;
	localparam int RSTEP_W    = $clog2(ROOT_W + 1);

	localparam logic [OUT_W-1:0] OUT_MAX = '1;

	// One channel's accumulator word as kept in the RAM
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [SUM_W-1:0] sum;
		logic [SQ_W-1:0]  sq;
	} acc_t;

	// Finished accumulation handed to the statistics unit
	typedef struct packed {
		logic [CH_W-1:0]  ch;
		logic [CNT_W-1:0] n;
		logic [SUM_W-1:0] sum;
		logic [SQ_W-1:0]  sq;
	} job_t;

	typedef enum logic {
		TS_IDLE,
		TS_UPDATE
	} top_state_t;

	typedef enum logic [2:0] {
		SS_IDLE,
		SS_MUL_LO,
		SS_MUL_HI,
		SS_DIFF,
		SS_DIV_MEAN,
		SS_DIV_VAR,
		SS_SQRT,
		SS_HOLD
	} stats_state_t;

endpackage

[sv/pmse_ram.sv]
module pmse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/pmse_div.sv]
module pmse_div import pmse_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DVD_W-1:0]  dvd,
	input  logic [DSR_W-1:0]  dsr,
	input  logic [STEP_W-1:0] steps,
	output logic              done,
	output logic [DVD_W-1:0]  quo
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DSR_W-1:0]  rem_q;
	logic [DSR_W-1:0]  dsr_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DSR_W:0]    trial;
	logic [DSR_W:0]    diff;
	logic              ge;

	// Restoring step: one quotient bit per cycle, MSB first
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		diff  = trial - {1'b0, dsr_q};
		ge    = (trial >= {1'b0, dsr_q});
	end

	// Step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - STEP_W'(1);
			busy_q <= (cnt_q != STEP_W'(1));
			done_q <= (cnt_q == STEP_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// Dividend shifts out at the top, quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dvd;
			rem_q <= '0;
			dsr_q <= dsr;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[sv/pmse_sqrt.sv]
module pmse_sqrt import pmse_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  rad,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	logic               busy_q;
	logic               done_q;
	logic [RSTEP_W-1:0] cnt_q;
	logic [RAD_W-1:0]   rad_q;
	logic [ROOT_W-1:0]  root_q;
	logic [REM_W-1:0]   rem_q;
	logic [REM_W+1:0]   cand;
	logic [REM_W+1:0]   trial;
	logic [REM_W+1:0]   diff;
	logic               ge;

	// Digit-by-digit root: two radicand bits in, one root bit out per cycle
	always_comb begin
		cand  = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
		diff  = cand - trial;
		ge    = (cand >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= RSTEP_W'(ROOT_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - RSTEP_W'(1);
			busy_q <= (cnt_q != RSTEP_W'(1));
			done_q <= (cnt_q == RSTEP_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			root_q <= {root_q[ROOT_W-2:0], ge};
			rem_q  <= ge ? diff[REM_W-1:0] : cand[REM_W-1:0];
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

[sv/pmse_stats.sv]
module pmse_stats import pmse_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_start,
	input  job_t             job,
	output logic             job_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [CH_W-1:0]  out_channel,
	output logic [OUT_W-1:0] pedestal_mean,
	output logic [OUT_W-1:0] pedestal_std
);

	stats_state_t      state_q, state_d;
	job_t              job_q;
	logic [PLO_W-1:0]  plo_q;
	logic [B_W-1:0]    b_q;
	logic [DEN_W-1:0]  den_q;
	logic [A_W-1:0]    a_q;
	logic [A_W-1:0]    d_q;
	logic [OUT_W-1:0]  mean_q;
	logic [OUT_W-1:0]  std_q;
	logic [PHI_W-1:0]  phi;
	logic [A_W-1:0]    b_ext;

	logic              div_start;
	logic [DVD_W-1:0]  div_dvd;
	logic [DSR_W-1:0]  div_dsr;
	logic [STEP_W-1:0] div_steps;
	logic              div_done;
	logic [DVD_W-1:0]  div_quo;
	logic              sqrt_start;
	logic              sqrt_done;
	logic [ROOT_W-1:0] sqrt_root;

	// Shared divider: mean first, then the variance
	pmse_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.dvd   (div_dvd),
		.dsr   (div_dsr),
		.steps (div_steps),
		.done  (div_done),
		.quo   (div_quo)
	);

	pmse_sqrt u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sqrt_start),
		.rad   (RAD_W'(div_quo)),
		.done  (sqrt_done),
		.root  (sqrt_root)
	);

	assign phi   = PHI_W'(job_q.n) * PHI_W'(job_q.sq[SQ_W-1:SQ_LO_W]);
	assign b_ext = A_W'(b_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer
	always_comb begin
		state_d    = state_q;
		job_ready  = 1'b0;
		out_valid  = 1'b0;
		div_start  = 1'b0;
		div_dvd    = {job_q.sum, {(DVD_W-SUM_W){1'b0}}};
		div_dsr    = DSR_W'(job_q.n);
		div_steps  = STEP_W'(MEAN_DVD_W);
		sqrt_start = 1'b0;
		case (state_q)
			SS_IDLE: begin
				job_ready = 1'b1;
				if (job_start) begin
					state_d = SS_MUL_LO;
				end
			end
			SS_MUL_LO: begin
				state_d = SS_MUL_HI;
			end
			SS_MUL_HI: begin
				state_d = SS_DIFF;
			end
			SS_DIFF: begin
				div_start = 1'b1;
				state_d   = SS_DIV_MEAN;
			end
			SS_DIV_MEAN: begin
				if (div_done) begin
					div_start = 1'b1;
					div_dvd   = {d_q, {VAR_FRAC{1'b0}}};
					div_dsr   = den_q;
					div_steps = STEP_W'(DVD_W);
					state_d   = SS_DIV_VAR;
				end
			end
			SS_DIV_VAR: begin
				if (div_done) begin
					sqrt_start = 1'b1;
					state_d    = SS_SQRT;
				end
			end
			SS_SQRT: begin
				if (sqrt_done) begin
					state_d = SS_HOLD;
				end
			end
			SS_HOLD: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = SS_IDLE;
				end
			end
			default: begin
				state_d = SS_IDLE;
			end
		endcase
	end

	// Products, variance numerator and saturated results
	always_ff @(posedge clk) begin
		case (state_q)
			SS_IDLE: begin
				if (job_start) begin
					job_q <= job;
				end
			end
			SS_MUL_LO: begin
				plo_q <= PLO_W'(job_q.n) * PLO_W'(job_q.sq[SQ_LO_W-1:0]);
				b_q   <= B_W'(job_q.sum) * B_W'(job_q.sum);
				den_q <= DEN_W'(job_q.n) * DEN_W'(job_q.n - CNT_W'(1));
			end
			SS_MUL_HI: begin
				a_q <= A_W'(plo_q) + (A_W'(phi) << SQ_LO_W);
			end
			SS_DIFF: begin
				d_q <= (a_q > b_ext) ? (a_q - b_ext) : '0;
			end
			SS_DIV_MEAN: begin
				if (div_done) begin
					mean_q <= (|div_quo[MEAN_DVD_W-1:OUT_W]) ? OUT_MAX : div_quo[OUT_W-1:0];
				end
			end
			SS_SQRT: begin
				if (sqrt_done) begin
					std_q <= (|sqrt_root[ROOT_W-1:OUT_W]) ? OUT_MAX : sqrt_root[OUT_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign out_channel   = job_q.ch;
	assign pedestal_mean = mean_q;
	assign pedestal_std  = std_q;

endmodule

[sv/pedestal_mean_std_estimator_core.sv]
// Channel   Handshake               Payload
// config    cfg_wr_en               cfg_wr_data (samples_per_pedestal)
// input     in_valid / in_ready     channel, waveform_start, sample
// output    out_valid / out_ready   out_channel, pedestal_mean, pedestal_std
//
// A sample is handled as a RAM read of the channel's accumulators, then update and write back.
// The sample that completes a pedestal also hands the sums to the statistics unit, which
// runs its SS_MUL_LO, SS_MUL_HI and SS_DIFF states, 28 + 57 divider steps and 29 root steps.
// Samples keep flowing meanwhile; a second completing sample waits until the previous
// result has been taken from the output register.
// Reset clears the control state and the per-channel valid bits; no clearing pass is needed.
module pedestal_mean_std_estimator_core import pmse_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CFG_W-1:0] cfg_wr_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CH_W-1:0]  channel,
	input  logic             waveform_start,
	input  logic [SMP_W-1:0] sample,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [CH_W-1:0]  out_channel,
	output logic [OUT_W-1:0] pedestal_mean,
	output logic [OUT_W-1:0] pedestal_std
);

	top_state_t             state_q, state_d;
	logic [CNT_W-1:0]       n_q;
	logic [CNT_W-1:0]       n_clamp;
	logic [CHANNELS-1:0]    valid_q;
	logic [CH_W-1:0]        ch_s1;
	logic                   start_s1;
	logic [SAMPLE_BITS-1:0] smp_s1;
	logic [ADDR_W-1:0]      addr_s1;
	logic [$bits(acc_t)-1:0] rd_data;
	acc_t                   rd_acc;
	acc_t                   old_acc;
	acc_t                   new_acc;
	logic [SQR_W-1:0]       smp_sq;
	logic                   ch_ok;
	logic                   live;
	logic                   final_smp;
	logic                   rd_en;
	logic                   wr_en;
	logic                   job_start;
	logic                   stats_ready;
	job_t                   job;

	assign ch_ok   = (32'(channel) < CHANNELS);
	assign addr_s1 = ch_s1[ADDR_W-1:0];
	assign rd_acc  = rd_data;

	// Effective sample count, clamped when written
	always_comb begin
		if (cfg_wr_data < CFG_W'(MIN_SAMPLES)) begin
			n_clamp = CNT_W'(MIN_SAMPLES);
		end else if (32'(cfg_wr_data) > MAX_SAMPLES) begin
			n_clamp = CNT_W'(MAX_SAMPLES);
		end else begin
			n_clamp = CNT_W'(cfg_wr_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= CNT_W'(DEFAULT_SAMPLES);
		end else if (cfg_wr_en) begin
			n_q <= n_clamp;
		end
	end

	// Read-modify-write of the channel's accumulators
	always_comb begin
		old_acc       = (start_s1 || !valid_q[addr_s1]) ? '0 : rd_acc;
		smp_sq        = SQR_W'(smp_s1) * SQR_W'(smp_s1);
		live          = (old_acc.count < n_q);
		new_acc.count = old_acc.count + CNT_W'(1);
		new_acc.sum   = old_acc.sum + SUM_W'(smp_s1);
		new_acc.sq    = old_acc.sq + SQ_W'(smp_sq);
		final_smp     = live && (new_acc.count == n_q);
		job.ch        = ch_s1;
		job.n         = n_q;
		job.sum       = new_acc.sum;
		job.sq        = new_acc.sq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control: accept, read, then write back, drop a sample past the count, or wait for the statistics unit
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		job_start = 1'b0;
		case (state_q)
			TS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && ch_ok) begin
					rd_en   = 1'b1;
					state_d = TS_UPDATE;
				end
			end
			TS_UPDATE: begin
				if (!live) begin
					state_d = TS_IDLE;
				end else if (!final_smp || stats_ready) begin
					wr_en     = 1'b1;
					job_start = final_smp;
					state_d   = TS_IDLE;
				end
			end
			default: begin
				state_d = TS_IDLE;
			end
		endcase
	end

	// Input transaction capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1    <= channel;
			start_s1 <= waveform_start;
			smp_s1   <= sample[SAMPLE_BITS-1:0];
		end
	end

	// Entries not yet written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[addr_s1] <= 1'b1;
		end
	end

	pmse_ram #(
		.WIDTH($bits(acc_t)),
		.DEPTH(CHANNELS)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(addr_s1),
		.wdata(new_acc),
		.re   (rd_en),
		.raddr(channel[ADDR_W-1:0]),
		.rdata(rd_data)
	);

	pmse_stats u_stats (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_start    (job_start),
		.job          (job),
		.job_ready    (stats_ready),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_channel  (out_channel),
		.pedestal_mean(pedestal_mean),
		.pedestal_std (pedestal_std)
	);

endmodule

[sv/pmse_checker.sv]
module pmse_checker import pmse_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [CH_W-1:0]  out_channel,
	input logic [OUT_W-1:0] pedestal_mean,
	input logic [OUT_W-1:0] pedestal_std
);

	localparam logic [OUT_W-1:0] MEAN_MAX = OUT_W'((2 ** MEAN_FRAC) * ((2 ** SAMPLE_BITS) - 1));

	// A stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_channel) &&
		$stable(pedestal_mean) && $stable(pedestal_std))
		else $error("result changed while stalled");

	// Each sample goes through a read cycle before the next is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on back-to-back cycles");

	// The statistics unit returns to idle once a result is taken, so out_valid drops before another result
	a_result_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid)
		else $error("result shown right after a transaction");

	// A mean can never exceed the largest sample value
	a_mean_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pedestal_mean <= MEAN_MAX)
		else $error("mean above sample range");

endmodule

bind pedestal_mean_std_estimator_core pmse_checker u_pmse_checker (.*);
